@@ rtl/grbf_pkg.sv @@
// ----------------------------------------------------------------------------
// grbf_pkg
// Shared constants, command and status types and the exp table generator
// for the Gaussian RBF evaluator.
// ----------------------------------------------------------------------------
package grbf_pkg;

  localparam int MAX_CENTERS       = 256;
  localparam int EXP_TABLE_ENTRIES = 256;

  localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam int          SERIES_TERMS = 13;

  localparam logic [1:0] MODE_LOAD_CENTER = 2'd0;
  localparam logic [1:0] MODE_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_QUERY       = 2'd2;

  localparam logic CFG_ACTIVE_CENTERS = 1'b0;
  localparam logic CFG_KERNEL_WIDTH   = 1'b1;

  localparam logic [8:0]  ACTIVE_CENTERS_RST = 9'd193;
  localparam logic [31:0] KERNEL_WIDTH_RST   = 32'd65536;

  typedef struct packed {
    logic wr_center;
    logic wr_weight;
    logic wr_bias;
    logic start;
    logic issue;
    logic finish;
  } grbf_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } grbf_sts_t;

  // 2^-k/N in Q1.16 from x = k * 2^32 / N, series for exp(-x ln2)
  function automatic logic [16:0] exp_from_x(input logic [63:0] x);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    z    = (x * {32'd0, LN2_Q32}) >> 32;
    term = 64'd1 << 32;
    pos  = term;
    neg  = 64'd0;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * z) >> 32) / 64'(n);
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = ((pos - neg) + 64'd32768) >> 16;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[16:0];
  endfunction

endpackage

@@ rtl/gaussian_rbf_evaluator.sv @@
// ----------------------------------------------------------------------------
// gaussian_rbf_evaluator
// Gaussian radial basis function evaluator, top level.
// ----------------------------------------------------------------------------
// Load transactions (center, weight, bias) are written straight from idle and
// leave the block ready for the next transaction. A query walks
// min(active_centers, MaxCenters) centers through a 13-stage pipeline (memory
// read, distance, split squares, kernel width multiply, log2 scaling, table
// interpolation, weight multiply), one center per cycle. The result sits in an
// output register while the next load or query is taken. Configuration writes
// take effect at once and must happen with the block idle.
// ----------------------------------------------------------------------------
module gaussian_rbf_evaluator
  import grbf_pkg::*;
#(
  parameter int MaxCenters = MAX_CENTERS,
  parameter int ExpEntries = EXP_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [8:0]         in_slot,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_weight_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_interpolated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (MaxCenters > 1) ? $clog2(MaxCenters) : 1;

  logic [8:0]    active_centers_r;
  logic [31:0]   kernel_width_r;
  grbf_cmd_t     cmd;
  grbf_sts_t     sts;
  logic [AW-1:0] issue_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_centers_r <= ACTIVE_CENTERS_RST;
      kernel_width_r   <= KERNEL_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_CENTERS: active_centers_r <= cfg_data[8:0];
        CFG_KERNEL_WIDTH:   kernel_width_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  grbf_ctrl #(
    .MaxCenters(MaxCenters)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_slot       (in_slot),
    .active_centers(active_centers_r),
    .sts           (sts),
    .cmd           (cmd),
    .issue_addr    (issue_addr)
  );

  grbf_dp #(
    .MaxCenters(MaxCenters),
    .ExpEntries(ExpEntries)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .issue_addr      (issue_addr),
    .in_slot         (in_slot),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_weight_value (in_weight_value),
    .kernel_width    (kernel_width_r),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_interpolated(out_interpolated)
  );

endmodule

@@ rtl/grbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// grbf_ctrl
// Controller: decodes input transactions, sequences the center walk of a
// query and hands the result to the output register.
// ----------------------------------------------------------------------------
module grbf_ctrl
  import grbf_pkg::*;
#(
  parameter int MaxCenters = MAX_CENTERS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [1:0]                                  in_mode,
  input  logic [8:0]                                  in_slot,
  input  logic [8:0]                                  active_centers,
  input  grbf_sts_t                                   sts,
  output grbf_cmd_t                                   cmd,
  output logic [((MaxCenters > 1) ? $clog2(MaxCenters) : 1)-1:0] issue_addr
);

  localparam int AW   = (MaxCenters > 1) ? $clog2(MaxCenters) : 1;
  localparam int CW   = $clog2(MaxCenters + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   last_r, last_nxt;
  logic            accept;
  logic            slot_ok;
  logic [CMPW-1:0] active_ext;
  logic [CMPW-1:0] cnt_eff;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign slot_ok    = CMPW'(in_slot) < CMPW'(MaxCenters);
  assign active_ext = CMPW'(active_centers);
  assign cnt_eff    = (active_ext > CMPW'(MaxCenters)) ? CMPW'(MaxCenters) : active_ext;
  assign issue_addr = addr_r;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    last_nxt       = last_r;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD_CENTER: begin
              cmd.wr_center = slot_ok;
            end
            MODE_LOAD_WEIGHT: begin
              cmd.wr_weight = slot_ok;
              cmd.wr_bias   = !slot_ok;
            end
            MODE_QUERY: begin
              cmd.start = 1'b1;
              addr_nxt  = '0;
              last_nxt  = AW'(cnt_eff - CMPW'(1));
              state_nxt = (cnt_eff == '0) ? ST_DRAIN : ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        addr_nxt  = addr_r + AW'(1);
        if (addr_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      last_r  <= last_nxt;
    end
  end

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> addr_r <= last_r)
    else $error("issue beyond last active center");

  a_finish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> $past(state_r) == ST_DRAIN || $past(state_r) == ST_FINISH)
    else $error("finish without drain");

  a_empty_query_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && cnt_eff == '0) |=> !cmd.issue)
    else $error("issue for query with no active centers");

endmodule

@@ rtl/grbf_dp.sv @@
// ----------------------------------------------------------------------------
// grbf_dp
// Datapath: center and weight memories, the per-center kernel pipeline,
// the accumulator and the output register.
// ----------------------------------------------------------------------------
module grbf_dp
  import grbf_pkg::*;
#(
  parameter int MaxCenters = MAX_CENTERS,
  parameter int ExpEntries = EXP_TABLE_ENTRIES
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  grbf_cmd_t                                   cmd,
  input  logic [((MaxCenters > 1) ? $clog2(MaxCenters) : 1)-1:0] issue_addr,
  input  logic [8:0]                                  in_slot,
  input  logic signed [31:0]                          in_coord_x,
  input  logic signed [31:0]                          in_coord_y,
  input  logic signed [31:0]                          in_weight_value,
  input  logic [31:0]                                 kernel_width,
  output grbf_sts_t                                   sts,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [47:0]                          out_interpolated
);

  localparam int AW      = (MaxCenters > 1) ? $clog2(MaxCenters) : 1;
  localparam int IW      = $clog2(ExpEntries);
  localparam int PW      = 16 + $clog2(ExpEntries + 1);
  localparam int NST     = 13;
  localparam int AccBase = 49 + $clog2(MaxCenters + 1);
  localparam int AccW    = (AccBase > 64) ? AccBase : 64;
  localparam int RW      = AccW - 16;

  logic signed [31:0] cx_mem [0:MaxCenters-1];
  logic signed [31:0] cy_mem [0:MaxCenters-1];
  logic signed [31:0] w_mem  [0:MaxCenters-1];
  logic [16:0]        exp_tab [0:ExpEntries];

  for (genvar k = 0; k <= ExpEntries; k++) begin : g_tab
    localparam logic [63:0] TabX = (64'(k) << 32) / 64'(ExpEntries);
    assign exp_tab[k] = exp_from_x(TabX);
  end

  logic [AW-1:0]      wr_addr;
  logic signed [31:0] bias_r;
  logic signed [31:0] qx_r, qy_r;
  logic [NST-1:0]     v_r;

  logic signed [31:0] s0_cx_r, s0_cy_r;
  logic signed [31:0] w_r [0:11];
  logic [32:0]        s1_mx_r, s1_my_r;
  logic [33:0]        s2_xhh_r, s2_yhh_r;
  logic [32:0]        s2_xhl_r, s2_yhl_r;
  logic [31:0]        s2_xll_r, s2_yll_r;
  logic [49:0]        s3_sqx_r, s3_sqy_r;
  logic [50:0]        s4_d2_r;
  logic [50:0]        s5_sh_r;
  logic [63:0]        s5_pl_r;
  logic [20:0]        s6_t_r;
  logic               s6_zero_r;
  logic [21:0]        s7_u_r;
  logic               s7_zero_r;
  logic [IW-1:0]      s8_idx_r;
  logic [15:0]        s8_rem_r;
  logic [4:0]         s8_n_r;
  logic               s8_zero_r;
  logic [16:0]        s9_a_r, s9_diff_r;
  logic [15:0]        s9_rem_r;
  logic [4:0]         s9_n_r;
  logic               s9_zero_r;
  logic [16:0]        s10_v_r;
  logic [4:0]         s10_n_r;
  logic               s10_zero_r;
  logic [16:0]        s11_e_r;
  logic signed [49:0] s12_prod_r;
  logic signed [AccW-1:0] acc_r;
  logic               out_valid_r;
  logic signed [47:0] out_interp_r;

  logic signed [32:0] dx, dy;
  logic [48:0]        t_sum;
  logic [37:0]        u_full;
  logic [PW-1:0]      p_full;
  logic [32:0]        lerp;
  logic signed [RW-1:0] res;
  logic               ovf;
  logic signed [47:0] res_sat;

  assign wr_addr = AW'(in_slot);
  assign dx      = {qx_r[31], qx_r} - {s0_cx_r[31], s0_cx_r};
  assign dy      = {qy_r[31], qy_r} - {s0_cy_r[31], s0_cy_r};
  assign t_sum   = {s5_sh_r[32:0], 16'd0} + {1'b0, s5_pl_r[63:16]};
  assign u_full  = {17'd0, s6_t_r} * {21'd0, LOG2E_Q16};
  assign p_full  = PW'(s7_u_r[15:0]) * PW'(ExpEntries);
  assign lerp    = {16'd0, s9_diff_r} * {17'd0, s9_rem_r};
  assign res     = RW'(acc_r >>> 16);
  assign ovf     = !((&res[RW-1:47]) || !(|res[RW-1:47]));
  assign res_sat = ovf ? (res[RW-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : res[47:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_center) begin
      cx_mem[wr_addr] <= in_coord_x;
      cy_mem[wr_addr] <= in_coord_y;
    end
    if (cmd.wr_weight) begin
      w_mem[wr_addr] <= in_weight_value;
    end
    s0_cx_r <= cx_mem[issue_addr];
    s0_cy_r <= cy_mem[issue_addr];
    w_r[0]  <= w_mem[issue_addr];
  end

  // kernel pipeline, one center per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
    end
    for (int i = 1; i < 12; i++) begin
      w_r[i] <= w_r[i-1];
    end
    s1_mx_r    <= dx[32] ? 33'(-dx) : 33'(dx);
    s1_my_r    <= dy[32] ? 33'(-dy) : 33'(dy);
    s2_xhh_r   <= {17'd0, s1_mx_r[32:16]} * {17'd0, s1_mx_r[32:16]};
    s2_xhl_r   <= {16'd0, s1_mx_r[32:16]} * {17'd0, s1_mx_r[15:0]};
    s2_xll_r   <= s1_mx_r[15:0] * s1_mx_r[15:0];
    s2_yhh_r   <= {17'd0, s1_my_r[32:16]} * {17'd0, s1_my_r[32:16]};
    s2_yhl_r   <= {16'd0, s1_my_r[32:16]} * {17'd0, s1_my_r[15:0]};
    s2_yll_r   <= s1_my_r[15:0] * s1_my_r[15:0];
    s3_sqx_r   <= {s2_xhh_r[33:0], 16'd0} + {16'd0, s2_xhl_r, 1'b0}
                  + {34'd0, s2_xll_r[31:16]};
    s3_sqy_r   <= {s2_yhh_r[33:0], 16'd0} + {16'd0, s2_yhl_r, 1'b0}
                  + {34'd0, s2_yll_r[31:16]};
    s4_d2_r    <= {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
    s5_sh_r    <= {19'd0, kernel_width} * {32'd0, s4_d2_r[50:32]};
    s5_pl_r    <= {32'd0, kernel_width} * {32'd0, s4_d2_r[31:0]};
    s6_zero_r  <= (|s5_sh_r[50:21]) || (|t_sum[48:21]);
    s6_t_r     <= t_sum[20:0];
    s7_u_r     <= u_full[37:16];
    s7_zero_r  <= s6_zero_r;
    s8_idx_r   <= p_full[IW+15:16];
    s8_rem_r   <= p_full[15:0];
    s8_n_r     <= s7_u_r[20:16];
    s8_zero_r  <= s7_zero_r || (s7_u_r[21:16] >= 6'd17);
    s9_a_r     <= exp_tab[s8_idx_r];
    s9_diff_r  <= exp_tab[s8_idx_r] - exp_tab[(IW+1)'(s8_idx_r) + (IW+1)'(1)];
    s9_rem_r   <= s8_rem_r;
    s9_n_r     <= s8_n_r;
    s9_zero_r  <= s8_zero_r;
    s10_v_r    <= s9_a_r - lerp[32:16];
    s10_n_r    <= s9_n_r;
    s10_zero_r <= s9_zero_r;
    s11_e_r    <= s10_zero_r ? 17'd0 : (s10_v_r >> s10_n_r);
    s12_prod_r <= w_r[11] * $signed({1'b0, s11_e_r});
    if (cmd.finish) begin
      out_interp_r <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      bias_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r <= {v_r[NST-2:0], cmd.issue};
      if (cmd.wr_bias) begin
        bias_r <= in_weight_value;
      end
      if (cmd.start) begin
        acc_r <= {{(AccW-48){bias_r[31]}}, bias_r, 16'd0};
      end else if (v_r[NST-1]) begin
        acc_r <= acc_r + AccW'(s12_prod_r);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.pipe_busy   = |v_r;
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_interpolated = out_interp_r;

  a_finish_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(|v_r))
    else $error("result taken while centers still in flight");

  a_start_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !(|v_r) && !cmd.issue)
    else $error("query started while pipeline active");

  a_load_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_center || cmd.wr_weight || cmd.wr_bias) |-> !(|v_r))
    else $error("store written during a query");

endmodule
